// ----- rtl/rcid_pkg.sv -----
// ----------------------------------------------------------------------------
// rcid_pkg
// Shared types and constants of the refcounted id cache table.
// ----------------------------------------------------------------------------
package rcid_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int SLOT_W        = 6;
  localparam int ID_W          = 32;
  localparam int REFS_W        = 16;

  localparam logic [ID_W-1:0] ID_LIMIT_RST = 32'd1024;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_DELETE = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_HIT     = 3'd1,
    ST_ALLOC   = 3'd2,
    ST_FULL    = 3'd3,
    ST_RANGE   = 3'd4,
    ST_ABSENT  = 3'd5,
    ST_FLUSHED = 3'd6,
    ST_CLEAN   = 3'd7
  } status_t;

  // one write into the table, any subset of the per-slot fields
  typedef struct packed {
    logic              valid_we;
    logic              valid_d;
    logic              dirty_we;
    logic              dirty_d;
    logic              tag_we;
    logic              refs_we;
    logic [IDX_W-1:0]  addr;
    logic [ID_W-1:0]   tag;
    logic [REFS_W-1:0] refs;
  } rcid_wr_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [REFS_W-1:0] refs;
    logic [ID_W-1:0]   id;
    logic              last;
  } rcid_res_t;

endpackage

// ----- rtl/rcid_store.sv -----
// ----------------------------------------------------------------------------
// rcid_store
// Slot storage: valid and dirty flags, id tags and reference counts.
// ----------------------------------------------------------------------------
module rcid_store
  import rcid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic [IDX_W-1:0]         rd_addr,
  output logic                     rd_valid,
  output logic [ID_W-1:0]          rd_tag,
  output logic [REFS_W-1:0]        rd_refs,
  output logic [CACHE_ENTRIES-1:0] valid_vec,
  output logic [CACHE_ENTRIES-1:0] dirty_vec,
  input  rcid_wr_t                 wr
);

  logic [CACHE_ENTRIES-1:0] valid_bits;
  logic [CACHE_ENTRIES-1:0] dirty_bits;
  logic [ID_W-1:0]          tags [CACHE_ENTRIES];
  logic [REFS_W-1:0]        refs [CACHE_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      dirty_bits <= '0;
    end else begin
      if (wr.valid_we) valid_bits[wr.addr] <= wr.valid_d;
      if (wr.dirty_we) dirty_bits[wr.addr] <= wr.dirty_d;
    end
  end

  // tags and counts are only read for valid slots
  always_ff @(posedge clk) begin
    if (wr.tag_we)  tags[wr.addr] <= wr.tag;
    if (wr.refs_we) refs[wr.addr] <= wr.refs;
  end

  assign rd_valid  = valid_bits[rd_addr];
  assign rd_tag    = tags[rd_addr];
  assign rd_refs   = refs[rd_addr];
  assign valid_vec = valid_bits;
  assign dirty_vec = dirty_bits;

endmodule

// ----- rtl/rcid_ctrl.sv -----
// ----------------------------------------------------------------------------
// rcid_ctrl
// Sequencer: walks the slots one per cycle through a single tag compare,
// applies the update and drives the result register.
// ----------------------------------------------------------------------------
module rcid_ctrl
  import rcid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               operation,
  input  logic [ID_W-1:0]          object_id,
  input  logic [ID_W-1:0]          id_limit,
  output logic                     out_valid,
  input  logic                     out_stall,
  output rcid_res_t                result,
  output logic [IDX_W-1:0]         rd_addr,
  input  logic                     rd_valid,
  input  logic [ID_W-1:0]          rd_tag,
  input  logic [REFS_W-1:0]        rd_refs,
  input  logic [CACHE_ENTRIES-1:0] valid_vec,
  input  logic [CACHE_ENTRIES-1:0] dirty_vec,
  output rcid_wr_t                 wr
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_ACT,
    S_FLUSH,
    S_EMIT
  } state_t;

  state_t            state;
  op_t               op_q;
  logic [ID_W-1:0]   id_q;
  logic [IDX_W-1:0]  idx;
  logic              found;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  rcid_res_t         res;
  rcid_res_t         out_q;
  logic              out_valid_q;

  logic                     accept;
  logic                     hit;
  logic                     out_free;
  logic [REFS_W-1:0]        refs_inc;
  logic [CACHE_ENTRIES-1:0] mask_le;
  logic                     flush_last;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign rd_addr    = idx;
  assign hit        = rd_valid && (rd_tag == id_q);
  assign out_free   = !out_valid_q || !out_stall;
  assign refs_inc   = (rd_refs == '1) ? rd_refs : rd_refs + REFS_W'(1);
  // slots at or below idx; the last flushed entry has nothing dirty above it
  assign mask_le    = (CACHE_ENTRIES'(2) << idx) - CACHE_ENTRIES'(1);
  assign flush_last = ~|(dirty_vec & ~mask_le);

  assign out_valid  = out_valid_q;
  assign result     = out_q;

  always_comb begin
    wr = '0;
    wr.addr = idx;
    wr.tag  = id_q;
    unique case (state)
      S_ACT: begin
        if (found) begin
          unique case (op_q)
            OP_READ: begin
              wr.refs_we = 1'b1;
              wr.refs    = refs_inc;
            end
            OP_WRITE: begin
              wr.dirty_we = 1'b1;
              wr.dirty_d  = 1'b1;
            end
            OP_DELETE: begin
              wr.valid_we = 1'b1;
              wr.dirty_we = 1'b1;
            end
            default: ;
          endcase
        end else if (op_q == OP_READ && free_found) begin
          wr.addr     = free_idx;
          wr.valid_we = 1'b1;
          wr.valid_d  = 1'b1;
          wr.dirty_we = 1'b1;
          wr.tag_we   = 1'b1;
          wr.refs_we  = 1'b1;
          wr.refs     = REFS_W'(1);
        end
      end
      S_FLUSH: begin
        wr.dirty_we = dirty_vec[idx];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) begin
        out_q       <= res;
        out_valid_q <= 1'b1;
      end else if (!out_stall) begin
        out_valid_q <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q       <= op_t'(operation);
            id_q       <= object_id;
            idx        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            if (op_t'(operation) == OP_FLUSH) begin
              if (dirty_vec == '0) begin
                res   <= '{ST_CLEAN, '0, '0, '0, 1'b1};
                state <= S_EMIT;
              end else begin
                state <= S_FLUSH;
              end
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (id_q >= id_limit) begin
            res   <= '{ST_RANGE, '0, '0, '0, 1'b1};
            state <= S_EMIT;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            found <= 1'b1;
            state <= S_ACT;
          end else begin
            if (!rd_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= idx;
            end
            if (idx == LAST_IDX) state <= S_ACT;
            else idx <= idx + IDX_W'(1);
          end
        end
        S_ACT: begin
          if (found) begin
            unique case (op_q)
              OP_READ:   res <= '{ST_HIT, SLOT_W'(idx), refs_inc, id_q, 1'b1};
              OP_WRITE:  res <= '{ST_DONE, SLOT_W'(idx), rd_refs, id_q, 1'b1};
              OP_DELETE: res <= '{ST_DONE, SLOT_W'(idx), '0, id_q, 1'b1};
              default:   res <= '{ST_DONE, '0, '0, '0, 1'b1};
            endcase
          end else if (op_q == OP_READ) begin
            if (free_found) res <= '{ST_ALLOC, SLOT_W'(free_idx), REFS_W'(1), id_q, 1'b1};
            else res <= '{ST_FULL, '0, '0, '0, 1'b1};
          end else begin
            res <= '{ST_ABSENT, '0, '0, '0, 1'b1};
          end
          state <= S_EMIT;
        end
        S_FLUSH: begin
          if (dirty_vec[idx]) begin
            res   <= '{ST_FLUSHED, SLOT_W'(idx), rd_refs, rd_tag, flush_last};
            state <= S_EMIT;
            if (!flush_last) idx <= idx + IDX_W'(1);
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_EMIT: begin
          if (out_free) state <= res.last ? S_IDLE : S_FLUSH;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a hit always lands on a valid slot
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACT && found) |-> rd_valid)
    else $error("hit recorded on an invalid slot");

  // allocation only claims a free slot
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACT && !found && op_q == OP_READ && free_found) |-> !valid_vec[free_idx])
    else $error("allocation into an occupied slot");

  // flush walk only runs while something is still dirty
  a_flush_dirty: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> (dirty_vec != '0))
    else $error("flush walk with no dirty slot");

  // the final result of an item returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free && res.last) |=> (state == S_IDLE))
    else $error("sequencer not idle after final result");

endmodule

// ----- rtl/refcounted_id_cache_table_unit.sv -----
// ----------------------------------------------------------------------------
// refcounted_id_cache_table_unit
// Fully associative table of object ids with reference counts and dirty marks.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall) carries operation and object_id; a
//   transaction is taken when in_valid is high and in_stall is low. The unit
//   works on one item at a time and holds in_stall high until the last result
//   of that item has been loaded into the output register.
//   out channel (out_valid/out_stall) carries status, slot, refcount,
//   entry_id and last; one output register decouples the two sides.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes id_limit; write only
//   while the unit is idle.
//   Read, write and delete pass through the id range check, then walk the
//   slots one per cycle through a single tag comparator, apply the update
//   and load the result into the output register; a hit ends the walk at
//   its slot, and an out of range id is answered without a walk.
//   A flush walks the slots up to the last dirty one and returns one result
//   per flushed entry; a flush with nothing dirty returns a CLEAN result.
//   A stalled receiver holds the result and pauses a flush walk.
//   Reset (synchronous, active high) clears all valid and dirty marks and
//   sets id_limit to 1024; the unit is ready in the next cycle.
// ----------------------------------------------------------------------------
module refcounted_id_cache_table_unit
  import rcid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic [ID_W-1:0]       object_id,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic [SLOT_W-1:0]     slot,
  output logic [REFS_W-1:0]     refcount,
  output logic [ID_W-1:0]       entry_id,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ID_W-1:0]       cfg_data
);

  logic [ID_W-1:0]          id_limit;
  rcid_res_t                result;
  rcid_wr_t                 wr;
  logic [IDX_W-1:0]         rd_addr;
  logic                     rd_valid;
  logic [ID_W-1:0]          rd_tag;
  logic [REFS_W-1:0]        rd_refs;
  logic [CACHE_ENTRIES-1:0] valid_vec;
  logic [CACHE_ENTRIES-1:0] dirty_vec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_limit <= ID_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      id_limit <= cfg_data;
    end
  end

  rcid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .object_id (object_id),
    .id_limit  (id_limit),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .rd_addr   (rd_addr),
    .rd_valid  (rd_valid),
    .rd_tag    (rd_tag),
    .rd_refs   (rd_refs),
    .valid_vec (valid_vec),
    .dirty_vec (dirty_vec),
    .wr        (wr)
  );

  rcid_store u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (rd_addr),
    .rd_valid  (rd_valid),
    .rd_tag    (rd_tag),
    .rd_refs   (rd_refs),
    .valid_vec (valid_vec),
    .dirty_vec (dirty_vec),
    .wr        (wr)
  );

  assign status    = result.status;
  assign slot      = result.slot;
  assign refcount  = result.refs;
  assign entry_id  = result.id;
  assign last      = result.last;

endmodule
